FILE: design/lpfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpfe_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LIMIT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NAMESPACE_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT     = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_MAX_FRAME_LENGTH  = 16'd4092;
  localparam logic [CFG_DATA_W-1:0] RST_SOURCE_LIMIT      = 16'd63;
  localparam logic [CFG_DATA_W-1:0] RST_DESTINATION_LIMIT = 16'd63;
  localparam logic [CFG_DATA_W-1:0] RST_NAMESPACE_LIMIT   = 16'd127;
  localparam logic [CFG_DATA_W-1:0] RST_PAYLOAD_LIMIT     = 16'd2047;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] max_frame_length;
    logic [CFG_DATA_W-1:0] source_limit;
    logic [CFG_DATA_W-1:0] destination_limit;
    logic [CFG_DATA_W-1:0] namespace_limit;
    logic [CFG_DATA_W-1:0] payload_limit;
  } lpfe_cfg_t;

  typedef struct packed {
    logic [1:0] field_id;
    logic [7:0] field_byte;
    logic       byte_valid;
    logic       field_end;
    logic       message_end;
    logic       oversize_error;
  } lpfe_result_t;

endpackage
`default_nettype wire

FILE: design/lpfe_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module lpfe_parser #(
  parameter int unsigned LENGTH_BITS = lpfe_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire lpfe_pkg::lpfe_cfg_t  cfg_i,
  output lpfe_pkg::lpfe_result_t    res_o,
  output logic                      res_valid_o
);
  import lpfe_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_SKIPV  = 3'd2,
    PH_SKIPB  = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5,
    PH_IGNORE = 3'd6
  } phase_e;

  localparam logic [16:0] FIELD_REM_MAX = 17'h1FFFF;
  localparam logic [3:0]  VARINT_STEP_MAX = 4'd10;

  phase_e                 phase_q, phase_d;
  logic [1:0]             hcnt_q, hcnt_d;
  logic [31:0]            hdr_q, hdr_d;
  logic [LENGTH_BITS-1:0] msg_q, msg_d;
  logic [16:0]            vacc_q, vacc_d;
  logic                   vhi_q, vhi_d;
  logic [3:0]             vstep_q, vstep_d;
  logic [2:0]             cur_q, cur_d;
  logic [16:0]            frem_q, frem_d;
  logic [15:0]            fcop_q, fcop_d;

  logic [16:0]            vacc_t;
  logic                   vhi_t;
  logic                   vlast;
  logic [15:0]            limit;
  logic [16:0]            frem_t;
  logic [LENGTH_BITS-1:0] msg_t;
  lpfe_result_t           res;

  // varint accumulation: low 17 bits kept, any higher set bit below bit 64 is sticky
  always_comb begin
    vacc_t = vacc_q;
    vhi_t  = vhi_q;
    vlast  = ~data_byte_i[7];
    case (vstep_q)
      4'd0: vacc_t[6:0]   = vacc_q[6:0] | data_byte_i[6:0];
      4'd1: vacc_t[13:7]  = vacc_q[13:7] | data_byte_i[6:0];
      4'd2: begin
        vacc_t[16:14] = vacc_q[16:14] | data_byte_i[2:0];
        vhi_t         = vhi_q | (data_byte_i[6:3] != 4'd0);
      end
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: vhi_t = vhi_q | (data_byte_i[6:0] != 7'd0);
      4'd9: vhi_t = vhi_q | data_byte_i[0];
      default: ;
    endcase
  end

  always_comb begin
    case (cur_q)
      3'd1:    limit = cfg_i.source_limit;
      3'd2:    limit = cfg_i.destination_limit;
      3'd3:    limit = cfg_i.namespace_limit;
      default: limit = cfg_i.payload_limit;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    hdr_d   = hdr_q;
    msg_d   = msg_q;
    vacc_d  = vacc_q;
    vhi_d   = vhi_q;
    vstep_d = vstep_q;
    cur_d   = cur_q;
    frem_d  = frem_q;
    fcop_d  = fcop_q;
    res     = '0;
    frem_t  = frem_q;
    msg_t   = msg_q;

    if (phase_q == PH_HEADER) begin
      hdr_d  = {hdr_q[23:0], data_byte_i};
      hcnt_d = hcnt_q + 2'd1;
      if (hcnt_q == 2'd3) begin
        if ((hdr_d > {16'd0, cfg_i.max_frame_length}) || ((hdr_d >> LENGTH_BITS) != 32'd0)) begin
          res.oversize_error = 1'b1;
        end else if (hdr_d == 32'd0) begin
          res.message_end = 1'b1;
        end else begin
          msg_d   = hdr_d[LENGTH_BITS-1:0];
          cur_d   = 3'd0;
          phase_d = PH_TAG;
          vacc_d  = '0;
          vhi_d   = 1'b0;
          vstep_d = '0;
        end
      end
    end else begin
      if (vstep_q != VARINT_STEP_MAX) begin
        vstep_d = vstep_q + 4'd1;
      end
      case (phase_q)
        PH_TAG: begin
          vacc_d = vacc_t;
          vhi_d  = vhi_t;
          if (vlast) begin
            vacc_d  = '0;
            vhi_d   = 1'b0;
            vstep_d = '0;
            case (vacc_t[2:0])
              3'd0: phase_d = PH_SKIPV;
              3'd1: begin
                phase_d = PH_SKIPB;
                frem_d  = 17'd8;
              end
              3'd5: begin
                phase_d = PH_SKIPB;
                frem_d  = 17'd4;
              end
              3'd2: begin
                phase_d = PH_LEN;
                if (vhi_t) begin
                  cur_d = 3'd0;
                end else begin
                  case (vacc_t[16:3])
                    14'd2:   cur_d = 3'd1;
                    14'd3:   cur_d = 3'd2;
                    14'd4:   cur_d = 3'd3;
                    14'd6:   cur_d = 3'd4;
                    default: cur_d = 3'd0;
                  endcase
                end
              end
              default: phase_d = PH_IGNORE;
            endcase
          end
        end
        PH_SKIPV: begin
          if (vlast) begin
            phase_d = PH_TAG;
            vacc_d  = '0;
            vhi_d   = 1'b0;
            vstep_d = '0;
          end
        end
        PH_SKIPB: begin
          if (frem_q != 17'd0) begin
            frem_t = frem_q - 17'd1;
          end
          frem_d = frem_t;
          if (frem_t == 17'd0) begin
            phase_d = PH_TAG;
            vacc_d  = '0;
            vhi_d   = 1'b0;
            vstep_d = '0;
          end
        end
        PH_LEN: begin
          vacc_d = vacc_t;
          vhi_d  = vhi_t;
          if (vlast) begin
            frem_t  = vhi_t ? FIELD_REM_MAX : vacc_t;
            frem_d  = frem_t;
            fcop_d  = '0;
            vacc_d  = '0;
            vhi_d   = 1'b0;
            vstep_d = '0;
            if (frem_t == 17'd0) begin
              if (cur_q != 3'd0) begin
                res.field_end = 1'b1;
                res.field_id  = 2'(cur_q - 3'd1);
              end
              cur_d   = 3'd0;
              phase_d = PH_TAG;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (cur_q != 3'd0) begin
            res.field_id = 2'(cur_q - 3'd1);
            if (fcop_q < limit) begin
              res.byte_valid = 1'b1;
              res.field_byte = data_byte_i;
              fcop_d         = fcop_q + 16'd1;
            end
          end
          if (frem_q != 17'd0) begin
            frem_t = frem_q - 17'd1;
          end
          frem_d = frem_t;
          if (frem_t == 17'd0) begin
            if (cur_q != 3'd0) begin
              res.field_end = 1'b1;
            end
            cur_d   = 3'd0;
            phase_d = PH_TAG;
            vacc_d  = '0;
            vhi_d   = 1'b0;
            vstep_d = '0;
          end
        end
        default: ;
      endcase

      if (msg_q != '0) begin
        msg_t = msg_q - LENGTH_BITS'(1);
      end
      msg_d = msg_t;
      if (msg_t == '0) begin
        if (cur_d != 3'd0) begin
          res.field_end = 1'b1;
          res.field_id  = 2'(cur_d - 3'd1);
        end
        res.message_end = 1'b1;
        cur_d   = 3'd0;
        phase_d = PH_HEADER;
        hcnt_d  = 2'd0;
        vacc_d  = '0;
        vhi_d   = 1'b0;
        vstep_d = '0;
      end
    end
  end

  assign res_o       = res;
  assign res_valid_o = res.byte_valid | res.field_end | res.message_end | res.oversize_error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= '0;
      hdr_q   <= '0;
      msg_q   <= '0;
      vacc_q  <= '0;
      vhi_q   <= 1'b0;
      vstep_q <= '0;
      cur_q   <= '0;
      frem_q  <= '0;
      fcop_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hdr_q   <= hdr_d;
      msg_q   <= msg_d;
      vacc_q  <= vacc_d;
      vhi_q   <= vhi_d;
      vstep_q <= vstep_d;
      cur_q   <= cur_d;
      frem_q  <= frem_d;
      fcop_q  <= fcop_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/lpfe_skid.sv
`timescale 1ns / 1ps
`default_nettype none
module lpfe_skid (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire lpfe_pkg::lpfe_result_t push_data_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  wire logic                  pop_ready_i,
  output lpfe_pkg::lpfe_result_t     data_o
);
  import lpfe_pkg::*;

  lpfe_result_t head_q, head_d;
  lpfe_result_t tail_q, tail_d;
  logic         hv_q, hv_d;
  logic         tv_q, tv_d;
  logic         pop;

  assign pop = hv_q & pop_ready_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    hv_d   = hv_q;
    tv_d   = tv_q;
    if (pop) begin
      if (tv_q) begin
        head_d = tail_q;
        tail_d = push_data_i;
        tv_d   = push_i;
      end else begin
        head_d = push_data_i;
        hv_d   = push_i;
      end
    end else if (push_i) begin
      if (!hv_q) begin
        head_d = push_data_i;
        hv_d   = 1'b1;
      end else begin
        tail_d = push_data_i;
        tv_d   = 1'b1;
      end
    end
  end

  assign ready_o = ~tv_q;
  assign valid_o = hv_q;
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      tv_q <= 1'b0;
    end else begin
      hv_q <= hv_d;
      tv_q <= tv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule
`default_nettype wire

FILE: design/length_framed_protobuf_field_extractor.sv
// Length-framed protobuf field extractor.
// s_axis carries the stream one byte per word: each frame is a 4-byte
// big-endian length followed by a protobuf message of that many bytes.
// m_axis carries the extracted words: passed bytes of fields 2, 3, 4 and 6
// tagged with field_id in tuser, field end, oversize error and message end
// (tlast). Bytes that cause no event produce no output word.
// The cfg channel writes max_frame_length and the four per-field limits by
// index; it is always ready and must only be used while the block is idle.
// Throughput is one byte per cycle while s_axis_tready is high: the parser
// state updates in the cycle a byte is taken, and its output word is registered.
// The output holds a two-word buffer, so s_axis_tready stays high while one
// word waits; it drops only when both words are held by a stalled receiver.
// Reset clears the parser to header phase, empties the output buffer and
// loads the register defaults (4092, 63, 63, 127, 2047).
`timescale 1ns / 1ps
`default_nettype none
module length_framed_protobuf_field_extractor #(
  parameter int unsigned LENGTH_BITS = lpfe_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,   // data_byte
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [15:0]                             m_axis_tdata,   // field_byte, field_end, oversize_error
  output logic [2:0]                              m_axis_tuser,   // field_id, byte_valid
  output logic                                    m_axis_tlast,   // message_end
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lpfe_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [lpfe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lpfe_pkg::*;

  lpfe_cfg_t    cfg_q;
  lpfe_result_t res;
  lpfe_result_t out;
  logic         res_valid;
  logic         take;
  logic         skid_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_length  <= RST_MAX_FRAME_LENGTH;
      cfg_q.source_limit      <= RST_SOURCE_LIMIT;
      cfg_q.destination_limit <= RST_DESTINATION_LIMIT;
      cfg_q.namespace_limit   <= RST_NAMESPACE_LIMIT;
      cfg_q.payload_limit     <= RST_PAYLOAD_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_FRAME_LENGTH:  cfg_q.max_frame_length  <= cfg_data_i;
        REG_SOURCE_LIMIT:      cfg_q.source_limit      <= cfg_data_i;
        REG_DESTINATION_LIMIT: cfg_q.destination_limit <= cfg_data_i;
        REG_NAMESPACE_LIMIT:   cfg_q.namespace_limit   <= cfg_data_i;
        REG_PAYLOAD_LIMIT:     cfg_q.payload_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = skid_ready;
  assign take          = s_axis_tvalid & skid_ready;

  lpfe_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (s_axis_tdata),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  lpfe_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take & res_valid),
    .push_data_i (res),
    .ready_o     (skid_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out)
  );

  assign m_axis_tdata = {6'd0, out.oversize_error, out.field_end, out.field_byte};
  assign m_axis_tuser = {out.byte_valid, out.field_id};
  assign m_axis_tlast = out.message_end;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lpfe_pkg::*;

  localparam int unsigned LEN_BITS = LENGTH_BITS_DEF;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic [2:0] FLD_NONE        = 3'd0;
  localparam logic [2:0] FLD_SOURCE      = 3'd1;
  localparam logic [2:0] FLD_DESTINATION = 3'd2;
  localparam logic [2:0] FLD_NAMESPACE   = 3'd3;
  localparam logic [2:0] FLD_PAYLOAD     = 3'd4;

  localparam logic [60:0] FN_SOURCE      = 61'd2;
  localparam logic [60:0] FN_DESTINATION = 61'd3;
  localparam logic [60:0] FN_NAMESPACE   = 61'd4;
  localparam logic [60:0] FN_PAYLOAD     = 61'd6;

  localparam logic [2:0] WT_VARINT      = 3'd0;
  localparam logic [2:0] WT_FIXED64     = 3'd1;
  localparam logic [2:0] WT_LEN         = 3'd2;
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_FIXED32     = 3'd5;
  localparam logic [2:0] WT_UNUSED_6    = 3'd6;
  localparam logic [2:0] WT_UNUSED_7    = 3'd7;

  typedef enum logic [2:0] {
    ST_HEADER, ST_TAG, ST_SKIP_VARINT, ST_SKIP_BYTES, ST_LENGTH, ST_DATA, ST_IGNORE
  } parse_state_e;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'd0;   // data_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;          // field_byte, field_end, oversize_error
  logic [2:0]             m_axis_tuser;          // field_id, byte_valid
  logic                   m_axis_tlast;          // message_end
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // register copies
  logic [15:0] max_frame_len = RST_MAX_FRAME_LENGTH;
  logic [15:0] source_lim    = RST_SOURCE_LIMIT;
  logic [15:0] dest_lim      = RST_DESTINATION_LIMIT;
  logic [15:0] ns_lim        = RST_NAMESPACE_LIMIT;
  logic [15:0] payload_lim   = RST_PAYLOAD_LIMIT;

  // parser copy
  parse_state_e parser_state = ST_HEADER;
  logic [1:0]   hdr_count = '0;
  logic [31:0]  hdr_acc = '0;
  logic [15:0]  msg_left = '0;
  logic [63:0]  vacc = '0;
  logic [6:0]   vshift = '0;
  logic [2:0]   cur_field = FLD_NONE;
  logic [16:0]  fld_left = '0;
  logic [15:0]  fld_copied = '0;

  logic [7:0]   stream_q[$];
  logic [7:0]   body[$];
  reg_write_t   reg_writes[$];
  lpfe_result_t predicted_words[$];

  int unsigned queued_bytes = 0;
  int unsigned errors = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned send_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned quiet_cycles = 0;

  length_framed_protobuf_field_extractor #(
    .LENGTH_BITS(LEN_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned next_gap(int unsigned pct);
    int unsigned roll;
    if ($urandom_range(99) >= pct) return 0;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------- parser prediction ----------------

  function automatic void enter_tag();
    parser_state = ST_TAG;
    vacc = '0;
    vshift = '0;
  endfunction

  function automatic bit take_varint(logic [7:0] b);
    if (vshift < 7'd64) vacc = vacc | ({57'd0, b[6:0]} << vshift);
    if (vshift < 7'd70) vshift = vshift + 7'd7;
    return !b[7];
  endfunction

  function automatic logic [2:0] route_of(logic [60:0] fnum);
    case (fnum)
      FN_SOURCE:      return FLD_SOURCE;
      FN_DESTINATION: return FLD_DESTINATION;
      FN_NAMESPACE:   return FLD_NAMESPACE;
      FN_PAYLOAD:     return FLD_PAYLOAD;
      default:        return FLD_NONE;
    endcase
  endfunction

  function automatic logic [15:0] limit_of(logic [2:0] f);
    case (f)
      FLD_SOURCE:      return source_lim;
      FLD_DESTINATION: return dest_lim;
      FLD_NAMESPACE:   return ns_lim;
      default:         return payload_lim;
    endcase
  endfunction

  function automatic logic [1:0] id_of(logic [2:0] f);
    logic [2:0] d;
    d = f - 3'd1;
    return d[1:0];
  endfunction

  task automatic parse_stream_byte(input logic [7:0] b, output lpfe_result_t r,
                                   output bit produced);
    logic [63:0] tag;
    r = '0;
    if (parser_state == ST_HEADER) begin
      hdr_acc = {hdr_acc[23:0], b};
      hdr_count = hdr_count + 2'd1;
      if (hdr_count == 2'd0) begin
        if (hdr_acc > 32'(max_frame_len) || (hdr_acc >> LEN_BITS) != 0) begin
          r.oversize_error = 1'b1;
        end else if (hdr_acc == 32'd0) begin
          r.message_end = 1'b1;
        end else begin
          msg_left = hdr_acc[15:0];
          cur_field = FLD_NONE;
          enter_tag();
        end
      end
    end else begin
      case (parser_state)
        ST_TAG: begin
          if (take_varint(b)) begin
            tag = vacc;
            vacc = '0;
            vshift = '0;
            case (tag[2:0])
              WT_VARINT: parser_state = ST_SKIP_VARINT;
              WT_FIXED64: begin
                parser_state = ST_SKIP_BYTES;
                fld_left = 17'd8;
              end
              WT_FIXED32: begin
                parser_state = ST_SKIP_BYTES;
                fld_left = 17'd4;
              end
              WT_LEN: begin
                cur_field = route_of(tag[63:3]);
                parser_state = ST_LENGTH;
              end
              default: parser_state = ST_IGNORE;
            endcase
          end
        end
        ST_SKIP_VARINT: begin
          if (!b[7]) enter_tag();
        end
        ST_SKIP_BYTES: begin
          if (fld_left != 0) fld_left = fld_left - 17'd1;
          if (fld_left == 0) enter_tag();
        end
        ST_LENGTH: begin
          if (take_varint(b)) begin
            fld_left = (vacc > 64'h1FFFF) ? 17'h1FFFF : vacc[16:0];
            fld_copied = '0;
            if (fld_left == 0) begin
              if (cur_field != FLD_NONE) begin
                r.field_end = 1'b1;
                r.field_id = id_of(cur_field);
              end
              cur_field = FLD_NONE;
              enter_tag();
            end else begin
              parser_state = ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (cur_field != FLD_NONE) begin
            r.field_id = id_of(cur_field);
            if (fld_copied < limit_of(cur_field)) begin
              r.byte_valid = 1'b1;
              r.field_byte = b;
              fld_copied = fld_copied + 16'd1;
            end
          end
          if (fld_left != 0) fld_left = fld_left - 17'd1;
          if (fld_left == 0) begin
            if (cur_field != FLD_NONE) r.field_end = 1'b1;
            cur_field = FLD_NONE;
            enter_tag();
          end
        end
        default: ;
      endcase
      if (msg_left != 0) msg_left = msg_left - 16'd1;
      if (msg_left == 0) begin
        if (cur_field != FLD_NONE) begin
          r.field_end = 1'b1;
          r.field_id = id_of(cur_field);
        end
        r.message_end = 1'b1;
        cur_field = FLD_NONE;
        parser_state = ST_HEADER;
        hdr_count = '0;
        vacc = '0;
        vshift = '0;
      end
    end
    produced = r.byte_valid | r.field_end | r.message_end | r.oversize_error;
  endtask

  // ---------------- drivers and monitor ----------------

  always @(posedge clk_i) begin : drive_stream
    lpfe_result_t word;
    bit produced;
    if (s_axis_tvalid && s_axis_tready) begin
      parse_stream_byte(s_axis_tdata, word, produced);
      if (produced) predicted_words.push_back(word);
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (stream_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stream_q.pop_front();
        send_gap = next_gap(send_idle);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : drive_config
    reg_write_t w;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_FRAME_LENGTH:  max_frame_len = cfg_data_i;
        REG_SOURCE_LIMIT:      source_lim = cfg_data_i;
        REG_DESTINATION_LIMIT: dest_lim = cfg_data_i;
        REG_NAMESPACE_LIMIT:   ns_lim = cfg_data_i;
        REG_PAYLOAD_LIMIT:     payload_lim = cfg_data_i;
        default: ;
      endcase
    end
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else if (!cfg_valid_i || cfg_ready_o) begin
      if (reg_writes.size() > 0) begin
        w = reg_writes.pop_front();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= w.index;
        cfg_data_i <= w.data;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  always @(posedge clk_i) begin : collect_words
    lpfe_result_t got;
    lpfe_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.field_id = m_axis_tuser[1:0];
      got.byte_valid = m_axis_tuser[2];
      got.field_byte = m_axis_tdata[7:0];
      got.field_end = m_axis_tdata[8];
      got.oversize_error = m_axis_tdata[9];
      got.message_end = m_axis_tlast;
      if (predicted_words.size() == 0) begin
        report_mismatch("word with nothing pending", int'(got), 0);
      end else begin
        want = predicted_words.pop_front();
        if (got.field_id != want.field_id)
          report_mismatch("field_id", got.field_id, want.field_id);
        if (got.field_byte != want.field_byte)
          report_mismatch("field_byte", got.field_byte, want.field_byte);
        if (got.byte_valid != want.byte_valid)
          report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
        if (got.field_end != want.field_end)
          report_mismatch("field_end", got.field_end, want.field_end);
        if (got.message_end != want.message_end)
          report_mismatch("message_end", got.message_end, want.message_end);
        if (got.oversize_error != want.oversize_error)
          report_mismatch("oversize_error", got.oversize_error, want.oversize_error);
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      rx_stall = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall = next_gap(recv_idle);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL length_framed_protobuf_field_extractor");
        $finish;
      end
    end
  end

  // ---------------- stream building ----------------

  task automatic push_byte(logic [7:0] b);
    stream_q.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_header(logic [31:0] len);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endtask

  task automatic add_varint(logic [63:0] v);
    logic [63:0] rest;
    rest = v;
    do begin
      body.push_back({rest[63:7] != 0, rest[6:0]});
      rest = rest >> 7;
    end while (rest != 0);
  endtask

  task automatic add_long_varint(int unsigned n);
    repeat (n - 1) body.push_back({1'b1, 7'($urandom)});
    body.push_back({1'b0, 7'($urandom)});
  endtask

  task automatic add_tag(logic [60:0] fnum, logic [2:0] wt);
    add_varint({fnum, wt});
  endtask

  task automatic add_bytes(int unsigned n);
    repeat (n) body.push_back(8'($urandom));
  endtask

  task automatic add_ld_field(logic [60:0] fnum, int unsigned n);
    add_tag(fnum, WT_LEN);
    add_varint(64'(n));
    add_bytes(n);
  endtask

  // a body too long for the current maximum goes out as a bare oversize header
  task automatic send_frame();
    push_header(body.size());
    if (body.size() <= max_frame_len)
      foreach (body[k]) push_byte(body[k]);
    body.delete();
  endtask

  task automatic send_cut_frame();
    int unsigned cut;
    if (body.size() < 2) begin
      send_frame();
    end else begin
      cut = $urandom_range(body.size() - 1, 1);
      if (cut > max_frame_len) begin
        send_frame();
      end else begin
        push_header(cut);
        for (int unsigned k = 0; k < cut; k++) push_byte(body[k]);
        body.delete();
      end
    end
  endtask

  function automatic logic [60:0] routed_number();
    case ($urandom_range(3))
      0: return FN_SOURCE;
      1: return FN_DESTINATION;
      2: return FN_NAMESPACE;
      default: return FN_PAYLOAD;
    endcase
  endfunction

  function automatic logic [60:0] any_number();
    if ($urandom_range(9) == 0) return 61'($urandom);
    return 61'($urandom_range(40));
  endfunction

  function automatic logic [2:0] bad_wire_type();
    case ($urandom_range(3))
      0: return WT_GROUP_START;
      1: return WT_GROUP_END;
      2: return WT_UNUSED_6;
      default: return WT_UNUSED_7;
    endcase
  endfunction

  task automatic add_random_element();
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(99);
    n = ($urandom_range(3) == 0) ? $urandom_range(20, 7) : $urandom_range(6);
    if ($urandom_range(24) == 0) n = $urandom_range(70, 60);
    if (roll < 45) begin
      add_ld_field(routed_number(), n);
    end else if (roll < 55) begin
      add_ld_field(any_number(), n);
    end else if (roll < 67) begin
      add_tag(any_number(), WT_VARINT);
      add_long_varint($urandom_range(10, 1));
    end else if (roll < 77) begin
      add_tag(any_number(), WT_FIXED64);
      add_bytes(8);
    end else if (roll < 87) begin
      add_tag(any_number(), WT_FIXED32);
      add_bytes(4);
    end else if (roll < 92) begin
      add_tag(any_number(), bad_wire_type());
      add_bytes($urandom_range(4));
    end else if (roll < 96) begin
      add_long_varint($urandom_range(11, 2));
    end else begin
      add_tag(routed_number(), WT_LEN);
      add_varint({$urandom, $urandom});
      add_bytes(n);
    end
  endtask

  task automatic add_random_frame();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) begin
      push_header(32'd0);
    end else if (roll < 8) begin
      if ($urandom_range(1)) push_header(32'(max_frame_len) + 32'd1);
      else push_header(32'(max_frame_len) + 32'd1 + $urandom_range(32'h7FFF_0000));
    end else if (roll < 13) begin
      add_bytes($urandom_range(12, 1));
      send_frame();
    end else begin
      repeat ($urandom_range(4, 1)) add_random_element();
      if (roll < 21) send_cut_frame();
      else send_frame();
    end
  endtask

  task automatic random_stream(int unsigned n);
    int unsigned target;
    target = queued_bytes + n;
    while (queued_bytes < target) add_random_frame();
  endtask

  task automatic settle();
    while (stream_q.size() != 0 || s_axis_tvalid || predicted_words.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] max_len, logic [15:0] src, logic [15:0] dst,
                            logic [15:0] nsp, logic [15:0] pay);
    reg_writes.push_back('{REG_MAX_FRAME_LENGTH, max_len});
    reg_writes.push_back('{REG_SOURCE_LIMIT, src});
    reg_writes.push_back('{REG_DESTINATION_LIMIT, dst});
    reg_writes.push_back('{REG_NAMESPACE_LIMIT, nsp});
    reg_writes.push_back('{REG_PAYLOAD_LIMIT, pay});
    @(posedge clk_i);
    while (reg_writes.size() != 0 || cfg_valid_i) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // register defaults
    send_idle = 20;
    recv_idle = 20;
    push_header(32'd0);
    push_header(32'(max_frame_len) + 32'd1);
    push_header(32'hFFFF_FFFF);
    add_ld_field(FN_SOURCE, 2);
    add_ld_field(FN_DESTINATION, 0);
    add_ld_field(FN_NAMESPACE, 1);
    add_ld_field(FN_PAYLOAD, 3);
    add_tag(61'd1, WT_VARINT);
    add_varint(64'd300);
    add_tag(61'd5, WT_FIXED32);
    add_bytes(4);
    add_tag(61'd7, WT_FIXED64);
    add_bytes(8);
    add_ld_field(61'd9, 2);
    add_ld_field(FN_SOURCE, 1);
    send_frame();
    // saturated field length, cut off by the message end
    add_tag(FN_PAYLOAD, WT_LEN);
    add_varint(64'hFFFF_FFFF_FFFF_FFFF);
    add_bytes(3);
    send_frame();
    add_long_varint(11);
    add_tag(61'd9, WT_GROUP_START);
    add_bytes(2);
    send_frame();
    // message ends inside a tag and inside a skipped varint
    body.push_back(8'h80);
    send_frame();
    add_tag(61'd1, WT_VARINT);
    body.push_back(8'hFF);
    send_frame();
    settle();

    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_requests++;
    send_idle = 0;
    recv_idle = 0;
    random_stream(200);
    settle();
    send_idle = 30;
    recv_idle = 30;
    random_stream(200);
    settle();

    write_regs(16'd48, 16'd0, 16'd1, 16'd2, 16'd5);
    send_idle = 50;
    recv_idle = 10;
    add_ld_field(FN_PAYLOAD, 46);
    send_frame();
    add_ld_field(FN_SOURCE, 47);
    send_frame();
    add_ld_field(FN_PAYLOAD, 5);
    add_ld_field(FN_PAYLOAD, 6);
    add_ld_field(FN_DESTINATION, 2);
    send_frame();
    random_stream(300);
    settle();

    write_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_idle = 10;
    recv_idle = 60;
    random_stream(100);
    settle();

    repeat (2) begin
      write_regs($urandom_range(200, 20), $urandom_range(20), $urandom_range(20),
                 $urandom_range(20), $urandom_range(20));
      send_idle = $urandom_range(60);
      recv_idle = $urandom_range(60);
      random_stream(250);
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (predicted_words.size() != 0)
      report_mismatch("words never delivered", 0, predicted_words.size());
    if (errors == 0) begin
      $display("PASS length_framed_protobuf_field_extractor");
    end else begin
      $display("FAIL length_framed_protobuf_field_extractor");
    end
    $finish;
  end

endmodule
